// ===== rtl/arpc_pkg.sv =====
// Shared types, constants and byte-lookup functions for the ARP responder frame classifier.
// Used by arpc_front, arpc_queue, arpc_back and the top level. No dependencies.
`default_nettype none

package arpc_pkg;

  localparam int unsigned IDX_W     = 11;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned REPLY_LEN = 60;
  localparam int unsigned MIN_FRAME = 60;
  localparam int unsigned ETH_HDR   = 14;

  localparam logic [15:0] TYPE_IP  = 16'h0800;
  localparam logic [15:0] TYPE_ARP = 16'h0806;
  localparam logic [15:0] OP_REQ   = 16'h0001;
  localparam logic [15:0] OP_REP   = 16'h0002;

  // Result kinds
  localparam logic [1:0] KIND_LEARN = 2'd0;
  localparam logic [1:0] KIND_TX    = 2'd1;
  localparam logic [1:0] KIND_IP    = 2'd2;

  // Configuration register indexes
  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  typedef enum logic [1:0] {
    JOB_IP,
    JOB_LEARN,
    JOB_REQ
  } job_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [10:0] ip_length;
    logic        run_last;
  } out_t;

  // One classified frame, handed from front to back
  typedef struct packed {
    job_kind_t   kind;
    logic [10:0] ip_length;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
  } job_t;

  // Fixed ARP header bytes 14..19 of a received frame
  function automatic logic [7:0] hdr_byte(input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h08;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Type, fixed header and opcode of the reply (reply bytes 12..21)
  function automatic logic [7:0] fixed_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = 8'h08;
      4'd1:    b = 8'h06;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h08;
      4'd5:    b = 8'h00;
      4'd6:    b = 8'h06;
      4'd7:    b = 8'h04;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
    logic [5:0] sel;
    sel = 6'(3'd5 - k) << 3;
    return mac[sel +: 8];
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
    logic [4:0] sel;
    sel = 5'(2'd3 - k) << 3;
    return ip[sel +: 8];
  endfunction

  // Byte i of the zero-padded ARP reply frame
  function automatic logic [7:0] reply_byte(input logic [5:0] i,
                                            input logic [47:0] peer_mac,
                                            input logic [31:0] peer_ip,
                                            input logic [47:0] own_mac,
                                            input logic [31:0] own_ip);
    logic [7:0] b;
    b = 8'h00;
    if (i < 6'd6) begin
      b = mac_byte(peer_mac, 3'(i));
    end else if (i < 6'd12) begin
      b = mac_byte(own_mac, 3'(i - 6'd6));
    end else if (i < 6'd22) begin
      b = fixed_byte(4'(i - 6'd12));
    end else if (i < 6'd28) begin
      b = mac_byte(own_mac, 3'(i - 6'd22));
    end else if (i < 6'd32) begin
      b = ip_byte(own_ip, 2'(i - 6'd28));
    end else if (i < 6'd38) begin
      b = mac_byte(peer_mac, 3'(i - 6'd32));
    end else if (i < 6'd42) begin
      b = ip_byte(peer_ip, 2'(i - 6'd38));
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/arpc_front.sv =====
// Receive-side parser: counts frame bytes, captures header fields, classifies at the last byte.
// Depends on arpc_pkg.
`default_nettype none

module arpc_front #(
  parameter int unsigned MAX_FRAME = 1514
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire arpc_pkg::in_t      item,
  input  wire logic [47:0]        own_mac,
  input  wire logic [31:0]        own_ip,
  output logic                    job_push,
  output arpc_pkg::job_t          job
);

  localparam logic [arpc_pkg::IDX_W-1:0] MAX_IDX = arpc_pkg::IDX_W'(MAX_FRAME);

  logic [arpc_pkg::IDX_W-1:0] byte_index;
  logic [15:0]                frame_type;
  logic                       arp_header_ok;
  logic [15:0]                arp_opcode;
  logic [47:0]                sender_hw_addr;
  logic [31:0]                sender_proto_addr;
  logic [31:0]                target_proto_addr;

  logic                       keep;
  logic [arpc_pkg::IDX_W-1:0] kept_len;
  logic                       hdr_match;
  logic                       long_enough;
  logic                       is_ip;
  logic                       arp_ok;
  logic                       is_req;
  logic                       is_rep;

  assign keep     = byte_index < MAX_IDX;
  assign kept_len = keep ? byte_index + arpc_pkg::IDX_W'(1) : byte_index;
  assign hdr_match = item.rx_byte == arpc_pkg::hdr_byte(3'(byte_index - 11'd14));

  // All captured fields end by byte 41, so any frame of 60 or more is complete here
  assign long_enough = kept_len >= arpc_pkg::IDX_W'(arpc_pkg::MIN_FRAME);
  assign is_ip  = frame_type == arpc_pkg::TYPE_IP;
  assign arp_ok = (frame_type == arpc_pkg::TYPE_ARP) && arp_header_ok &&
                  (target_proto_addr == own_ip);
  assign is_req = arp_ok && (arp_opcode == arpc_pkg::OP_REQ);
  assign is_rep = arp_ok && (arp_opcode == arpc_pkg::OP_REP);

  assign job_push = take && item.rx_last && long_enough && (is_ip || is_req || is_rep);

  always_comb begin
    job           = '0;
    job.kind      = is_ip ? arpc_pkg::JOB_IP : (is_req ? arpc_pkg::JOB_REQ : arpc_pkg::JOB_LEARN);
    job.ip_length = kept_len - arpc_pkg::IDX_W'(arpc_pkg::ETH_HDR);
    job.peer_mac  = sender_hw_addr;
    job.peer_ip   = sender_proto_addr;
    job.own_mac   = own_mac;
    job.own_ip    = own_ip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (take) begin
      if (item.rx_last) begin
        byte_index <= '0;
      end else begin
        byte_index <= kept_len;
      end
    end
  end

  // Field capture; every field is rewritten by each frame before it is looked at
  always_ff @(posedge clk) begin
    if (take && keep) begin
      if (byte_index == 11'd12 || byte_index == 11'd13) begin
        frame_type <= {frame_type[7:0], item.rx_byte};
      end else if (byte_index >= 11'd14 && byte_index <= 11'd19) begin
        arp_header_ok <= (byte_index == 11'd14) ? hdr_match : (arp_header_ok & hdr_match);
      end else if (byte_index == 11'd20 || byte_index == 11'd21) begin
        arp_opcode <= {arp_opcode[7:0], item.rx_byte};
      end else if (byte_index >= 11'd22 && byte_index <= 11'd27) begin
        sender_hw_addr <= {sender_hw_addr[39:0], item.rx_byte};
      end else if (byte_index >= 11'd28 && byte_index <= 11'd31) begin
        sender_proto_addr <= {sender_proto_addr[23:0], item.rx_byte};
      end else if (byte_index >= 11'd38 && byte_index <= 11'd41) begin
        target_proto_addr <= {target_proto_addr[23:0], item.rx_byte};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arpc_queue.sv =====
// Two-entry job queue between the parser and the result generator.
// Depends on arpc_pkg.
`default_nettype none

module arpc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire arpc_pkg::job_t din,
  input  wire logic           rd,
  output arpc_pkg::job_t      head,
  output logic                q_empty,
  output logic                q_full
);

  arpc_pkg::job_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign q_empty = count == 2'd0;
  assign q_full  = count == 2'd2;
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arpc_back.sv =====
// Result generator: walks the head job, one result per transfer, into an output register.
// Depends on arpc_pkg.
`default_nettype none

module arpc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire arpc_pkg::job_t head,
  input  wire logic           q_empty,
  output logic                job_pop,
  output logic                empty,
  input  wire logic           pop,
  output arpc_pkg::out_t      result
);

  localparam logic [arpc_pkg::STEP_W-1:0] LAST_STEP = arpc_pkg::STEP_W'(arpc_pkg::REPLY_LEN);

  logic [arpc_pkg::STEP_W-1:0] step;
  logic                        out_valid;
  logic                        out_free;
  logic                        fire;
  arpc_pkg::out_t              r;

  assign out_free = !out_valid || pop;
  assign fire     = !q_empty && out_free;
  assign job_pop  = fire && r.run_last;
  assign empty    = !out_valid;

  always_comb begin
    r = '0;
    unique case (head.kind)
      arpc_pkg::JOB_IP: begin
        r.kind      = arpc_pkg::KIND_IP;
        r.ip_length = head.ip_length;
        r.run_last  = 1'b1;
      end
      arpc_pkg::JOB_LEARN: begin
        r.kind     = arpc_pkg::KIND_LEARN;
        r.peer_mac = head.peer_mac;
        r.peer_ip  = head.peer_ip;
        r.run_last = 1'b1;
      end
      arpc_pkg::JOB_REQ: begin
        if (step == '0) begin
          r.kind     = arpc_pkg::KIND_LEARN;
          r.peer_mac = head.peer_mac;
          r.peer_ip  = head.peer_ip;
        end else begin
          r.kind     = arpc_pkg::KIND_TX;
          r.tx_byte  = arpc_pkg::reply_byte(step - 6'd1, head.peer_mac, head.peer_ip,
                                            head.own_mac, head.own_ip);
          r.run_last = step == LAST_STEP;
        end
      end
      default: begin
        r.run_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        step      <= r.run_last ? '0 : step + 6'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arp_responder_frame_classifier.sv =====
// ARP responder frame classifier, top level: config registers, parser, job queue, generator.
// Depends on arpc_pkg, arpc_front, arpc_queue and arpc_back.
//
// Usage
//   Input queue side: one received Ethernet byte per transfer (push while full is low),
//   starting at the destination MAC, rx_last on the final byte. A frame streams in at
//   one byte per cycle; full only rises while two classified frames wait for output.
//   Output queue side: results sit on result while empty is low; pop takes one.
//   An IPv4 frame gives one result (its kept length minus 14); an ARP request or reply for
//   own_ip with a good fixed header gives a learn result, and a request adds the 60 bytes
//   of the reply, 61 in all. Frames under 60 bytes, other types and other ARP give nothing.
// Result timing and rate
//   The first result of a frame passes the job queue and then the output register after
//   its last byte is taken, if no earlier job waits and the output is free. Results then
//   leave at one per cycle while pop is high; the rate is set by the single output register.
// Reset and stalls
//   rst (synchronous) clears the byte count, job queue, output valid flag and own_mac
//   and own_ip. A stalled receiver holds the current result; the two-entry job queue
//   absorbs frames behind it until it fills, after which full holds the sender.
//   own_mac and own_ip are sampled when a frame's last byte is taken.
`default_nettype none

module arp_responder_frame_classifier #(
  parameter int unsigned MAX_FRAME = 1514
) (
  input  wire logic           clk,
  input  wire logic           rst,
  // configuration
  input  wire logic           wr_en,
  input  wire logic           wr_index,
  input  wire logic [47:0]    wr_data,
  // receive bytes
  input  wire logic           push,
  output logic                full,
  input  wire arpc_pkg::in_t  item,
  // results
  output logic                empty,
  input  wire logic           pop,
  output arpc_pkg::out_t      result
);

  logic [47:0]    own_mac;
  logic [31:0]    own_ip;

  logic           take;
  logic           job_push;
  logic           job_pop;
  logic           job_empty;
  logic           job_full;
  arpc_pkg::job_t job_in;
  arpc_pkg::job_t job_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        arpc_pkg::REG_OWN_MAC: own_mac <= wr_data;
        arpc_pkg::REG_OWN_IP:  own_ip  <= wr_data[31:0];
        default:               own_ip  <= own_ip;
      endcase
    end
  end

  // Back-pressure only when no room for a classified frame
  assign full = job_full;
  assign take = push && !full;

  arpc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .own_mac  (own_mac),
    .own_ip   (own_ip),
    .job_push (job_push),
    .job      (job_in)
  );

  arpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .din     (job_in),
    .rd      (job_pop),
    .head    (job_head),
    .q_empty (job_empty),
    .q_full  (job_full)
  );

  arpc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (job_head),
    .q_empty (job_empty),
    .job_pop (job_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // A job is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(job_push && job_full))
    else $error("job queue overflow");

  // Only a final byte can create a job
  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
                                   job_push |-> (take && item.rx_last))
    else $error("job pushed without a final byte transfer");

  // A job is only retired while one is present, and then a result is loaded
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
                                job_pop |=> (!empty && result.run_last))
    else $error("job retired without its final result");

endmodule

`default_nettype wire

// ===== sim/arpc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the ARP responder frame classifier: predicts the results of each
// received byte and compares them with what leaves the output queue. Depends on arpc_pkg.

module arpc_result_checker #(
  parameter int unsigned MAX_FRAME = 1514
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic [47:0]              wr_data,
  input  logic                     push,
  input  logic                     full,
  input  arpc_pkg::in_t            item,
  input  logic                     empty,
  input  logic                     pop,
  input  arpc_pkg::out_t           result,
  output int                       mismatches,
  output int                       pending
);

  localparam logic [15:0]     HW_ETHER  = 16'h0001;
  localparam logic [7:0]      MAC_BYTES = 8'd6;
  localparam logic [7:0]      IP_BYTES  = 8'd4;
  localparam logic [0:5][7:0] ARP_FIXED = {HW_ETHER, arpc_pkg::TYPE_IP, MAC_BYTES, IP_BYTES};

  logic [47:0]    own_mac;
  logic [31:0]    own_ip;
  logic [10:0]    byte_count;
  logic [15:0]    eth_type;
  logic           arp_hdr_good;
  logic [15:0]    arp_op;
  logic [47:0]    src_mac;
  logic [31:0]    src_ip;
  logic [31:0]    dst_ip;
  arpc_pkg::out_t awaited_results[$];

  task automatic clear_frame();
    byte_count   = '0;
    eth_type     = '0;
    arp_hdr_good = 1'b0;
    arp_op       = '0;
    src_mac      = '0;
    src_ip       = '0;
    dst_ip       = '0;
  endtask

  task automatic note_result(input logic [1:0] kind, input logic [7:0] tx,
                             input logic [47:0] mac, input logic [31:0] ip,
                             input logic [10:0] len);
    arpc_pkg::out_t r;
    r           = '0;
    r.kind      = kind;
    r.tx_byte   = tx;
    r.peer_mac  = mac;
    r.peer_ip   = ip;
    r.ip_length = len;
    awaited_results.push_back(r);
  endtask

  // Capture fields while the frame streams in; classify on the final byte
  task automatic absorb_rx_byte(input logic [7:0] b, input logic fin);
    logic [0:arpc_pkg::REPLY_LEN-1][7:0] reply;
    int                                  queued_n;
    logic                                ok;
    arpc_pkg::out_t                      tail;
    if (byte_count < MAX_FRAME) begin
      if (byte_count == 11'd12 || byte_count == 11'd13) begin
        eth_type = {eth_type[7:0], b};
      end else if (byte_count >= 11'd14 && byte_count <= 11'd19) begin
        ok = (b == ARP_FIXED[byte_count - 11'd14]);
        arp_hdr_good = (byte_count == 11'd14) ? ok : (arp_hdr_good & ok);
      end else if (byte_count == 11'd20 || byte_count == 11'd21) begin
        arp_op = {arp_op[7:0], b};
      end else if (byte_count >= 11'd22 && byte_count <= 11'd27) begin
        src_mac = {src_mac[39:0], b};
      end else if (byte_count >= 11'd28 && byte_count <= 11'd31) begin
        src_ip = {src_ip[23:0], b};
      end else if (byte_count >= 11'd38 && byte_count <= 11'd41) begin
        dst_ip = {dst_ip[23:0], b};
      end
      byte_count++;
    end
    if (fin) begin
      queued_n = awaited_results.size();
      if (byte_count >= arpc_pkg::MIN_FRAME) begin
        if (eth_type == arpc_pkg::TYPE_IP) begin
          note_result(arpc_pkg::KIND_IP, '0, '0, '0, byte_count - 11'(arpc_pkg::ETH_HDR));
        end else if (eth_type == arpc_pkg::TYPE_ARP && arp_hdr_good && dst_ip == own_ip &&
                     (arp_op == arpc_pkg::OP_REQ || arp_op == arpc_pkg::OP_REP)) begin
          note_result(arpc_pkg::KIND_LEARN, '0, src_mac, src_ip, '0);
          if (arp_op == arpc_pkg::OP_REQ) begin
            // reply frame laid out whole, zero padding at the tail
            reply = {src_mac, own_mac, arpc_pkg::TYPE_ARP, HW_ETHER, arpc_pkg::TYPE_IP,
                     MAC_BYTES, IP_BYTES, arpc_pkg::OP_REP, own_mac, own_ip, src_mac,
                     src_ip, 144'd0};
            for (int i = 0; i < arpc_pkg::REPLY_LEN; i++) begin
              note_result(arpc_pkg::KIND_TX, reply[i], '0, '0, '0);
            end
          end
        end
      end
      if (awaited_results.size() > queued_n) begin
        tail = awaited_results.pop_back();
        tail.run_last = 1'b1;
        awaited_results.push_back(tail);
      end
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input arpc_pkg::out_t got);
    arpc_pkg::out_t want;
    if (awaited_results.size() == 0) begin
      $error("result with nothing awaited: kind %0d tx_byte %0h", got.kind, got.tx_byte);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("peer_mac", want.peer_mac, got.peer_mac);
      check_field("peer_ip", want.peer_ip, got.peer_ip);
      check_field("ip_length", want.ip_length, got.ip_length);
      check_field("run_last", want.run_last, got.run_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_mac = '0;
      own_ip  = '0;
      clear_frame();
      awaited_results.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == arpc_pkg::REG_OWN_MAC) own_mac = wr_data;
        else own_ip = wr_data[31:0];
      end
      if (pop && !empty) check_result(result);
      if (push && !full) absorb_rx_byte(item.rx_byte, item.rx_last);
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== sim/arp_responder_frame_classifier_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the ARP responder frame classifier: builds frames, writes the station
// registers and idles both queue sides. Depends on arpc_pkg, the block and arpc_result_checker.

module arp_responder_frame_classifier_test;

  localparam int unsigned MAX_FRAME     = 1514;
  localparam int unsigned SETTLE_CYCLES = 16;      // output register plus two-entry job queue
  localparam int unsigned STALL_CYCLES  = 500;     // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT   = 20000;

  // header constants used to build frames
  localparam logic [15:0] HW_ETHER   = 16'h0001;
  localparam logic [7:0]  MAC_BYTES  = 8'd6;
  localparam logic [7:0]  IP_BYTES   = 8'd4;
  localparam int          ARP_BARE   = 42;         // ARP packet without pad: a runt

  logic           clk;
  logic           rst      = 1'b1;
  logic           wr_en    = 1'b0;
  logic           wr_index = 1'b0;
  logic [47:0]    wr_data  = '0;
  logic           push     = 1'b0;
  logic           full;
  arpc_pkg::in_t  item     = '0;
  logic           empty;
  logic           pop      = 1'b0;
  arpc_pkg::out_t result;

  int          mismatches;
  int          pending;
  int unsigned snd_idle;       // percent of cycles the sender holds back
  int unsigned rcv_idle;       // percent of cycles the receiver holds back
  int unsigned cycle_count;
  bit          long_stall;
  logic [31:0] station_ip;
  logic [7:0]  frame_bytes[$];

  arp_responder_frame_classifier #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .push, .full, .item, .empty, .pop, .result
  );

  arpc_result_checker #(.MAX_FRAME(MAX_FRAME)) watch (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .push, .full, .item, .empty, .pop, .result,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random pop, or a long hold-off on request so the job queue fills and
  // full pushes back on the sender
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall) begin
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        long_stall = 1'b0;
      end
      pop <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // One byte transfer; push stays high into the next byte unless an idle is drawn
  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{rx_byte: b, rx_last: fin};
    do @(posedge clk); while (full);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Sender pauses until every awaited result is out, then lets the block go quiet;
  // a frame with no result may still be passing through the parser
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Station registers, written only while the block is idle
  task automatic set_station(input logic [47:0] mac, input logic [31:0] ip);
    station_ip  = ip;
    wr_en    <= 1'b1;
    wr_index <= arpc_pkg::REG_OWN_MAC;
    wr_data  <= mac;
    @(posedge clk);
    wr_index <= arpc_pkg::REG_OWN_IP;
    wr_data  <= {16'h0000, ip};
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // n bytes of v, most significant first (wire order)
  task automatic add_bytes(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) frame_bytes.push_back(v[8*k +: 8]);
  endtask

  // grow with random bytes or cut back to exactly len
  task automatic pad_to(input int len);
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endtask

  // destination (broadcast half the time), source, type
  task automatic build_eth(input logic [15:0] etype);
    frame_bytes.delete();
    if ($urandom_range(1)) add_bytes(48'hFFFF_FFFF_FFFF, 6);
    else add_bytes({$urandom, $urandom}, 6);
    add_bytes({$urandom, $urandom}, 6);
    add_bytes(etype, 2);
  endtask

  task automatic build_ip(input int len);
    build_eth(arpc_pkg::TYPE_IP);
    pad_to(len);
  endtask

  task automatic build_arp(input logic [15:0] op, input logic [31:0] tpa, input int len,
                           input bit bad_hdr);
    int unsigned spoil;
    build_eth(arpc_pkg::TYPE_ARP);
    add_bytes({HW_ETHER, arpc_pkg::TYPE_IP, MAC_BYTES, IP_BYTES}, 6);
    if (bad_hdr) begin
      // flip some bits in one fixed header byte
      spoil = 14 + $urandom_range(5);
      frame_bytes[spoil] = frame_bytes[spoil] ^ 8'($urandom_range(255, 1));
    end
    add_bytes(op, 2);
    add_bytes({$urandom, $urandom}, 6);   // sender MAC
    add_bytes($urandom, 4);               // sender IP
    add_bytes({$urandom, $urandom}, 6);   // target MAC
    add_bytes(tpa, 4);
    pad_to(len);
  endtask

  // short IPv4 frames, at or just over the minimum
  function automatic int ip_len();
    return $urandom_range(70, arpc_pkg::MIN_FRAME);
  endfunction

  function automatic int arp_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return arpc_pkg::MIN_FRAME;
    if (p < 95) return $urandom_range(90, arpc_pkg::MIN_FRAME + 1);
    return $urandom_range(arpc_pkg::MIN_FRAME - 1, ARP_BARE);
  endfunction

  // Mostly well-formed ARP and IPv4 traffic, the rest broken or foreign frames and noise
  task automatic random_frame();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 35) build_arp(arpc_pkg::OP_REQ, station_ip, arp_len(), 1'b0);
    else if (p < 50) build_arp(arpc_pkg::OP_REP, station_ip, arp_len(), 1'b0);
    else if (p < 70) build_ip(ip_len());
    else if (p < 76) build_arp($urandom_range(1) ? arpc_pkg::OP_REQ : arpc_pkg::OP_REP,
                               station_ip, arpc_pkg::MIN_FRAME, 1'b1);
    else if (p < 82) build_arp(arpc_pkg::OP_REQ, station_ip ^ (32'd1 << $urandom_range(31)),
                               arpc_pkg::MIN_FRAME, 1'b0);
    else if (p < 86) build_arp(16'($urandom), station_ip, arpc_pkg::MIN_FRAME, 1'b0);
    else if (p < 92) begin
      build_ip(arpc_pkg::MIN_FRAME);
      pad_to($urandom_range(arpc_pkg::MIN_FRAME - 1, 1));
    end else begin
      frame_bytes.delete();
      pad_to($urandom_range(100, 1));
    end
    send_frame();
  endtask

  initial begin
    snd_idle = 14;
    rcv_idle = 60;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Register extremes first: all zeros, receiver idles more than the sender
    set_station('0, '0);
    build_ip(1);                           send_frame();  // final flag on the first byte

    // Receiver holds off while frames keep coming: a request and an IPv4 frame fill the
    // job queue, full rises and holds the next frame back
    long_stall = 1'b1;
    build_arp(arpc_pkg::OP_REQ, station_ip, arpc_pkg::MIN_FRAME, 1'b0); send_frame();
    build_ip(arpc_pkg::MIN_FRAME);         send_frame();  // shortest IPv4
    build_ip(1);                           send_frame();
    settle();

    // All ones, idling swapped: learn without a reply, then an unpadded runt
    set_station('1, '1);
    snd_idle = 60;
    rcv_idle = 14;
    build_arp(arpc_pkg::OP_REP, station_ip, arpc_pkg::MIN_FRAME, 1'b0); send_frame();
    build_arp(arpc_pkg::OP_REQ, station_ip, ARP_BARE, 1'b0);            send_frame();
    settle();

    // Random station, no idling on either side
    set_station(48'({$urandom, $urandom}), $urandom);
    snd_idle = 0;
    rcv_idle = 0;
    random_frame();

    settle();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/arpc_pkg.sv
rtl/arpc_front.sv
rtl/arpc_queue.sv
rtl/arpc_back.sv
rtl/arp_responder_frame_classifier.sv
sim/arpc_result_checker.sv
sim/arp_responder_frame_classifier_test.sv
